// ===== hw/rtl/clrf_pkg.sv =====
// Shared types and constants for the command-list rectangle fill block.
// Used by the register file, the fill engine and the top level.
package clrf_pkg;

  localparam int unsigned AddrBits  = 32;
  localparam int unsigned HalfBits  = 16;
  localparam logic [31:0] AddrMask  = 32'((64'd1 << AddrBits) - 64'd1);

  typedef enum logic [1:0] {
    ModeWord    = 2'd0,
    ModeTick    = 2'd1,
    ModeRestart = 2'd2,
    ModeNone    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnknownOp = 2'd1,
    StBusy      = 2'd2,
    StHalted    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegFbWidth    = 2'd0,
    RegBlitOpcode = 2'd1,
    RegEndOpcode  = 2'd2,
    RegNone       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [HalfBits-1:0] fb_width;
    logic [HalfBits-1:0] blit_opcode;
    logic [HalfBits-1:0] end_opcode;
  } cfg_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [31:0] write_color;
    logic        fill_last;
    logic        busy_res;
    status_e     status;
  } res_t;

endpackage

// ===== hw/rtl/command_list_rect_fill.sv =====
// Command-list rectangle fill: input register, fill engine, result register.
// Path: an input transfer passes the input register, then the result register, to the master side.
// Throughput: one transfer per cycle while the master side accepts results; the 17x16 address multiplier sets the path.
// Reset: asynchronous, active low; clears the valid flags of both pipeline registers
// and the fill state, and loads fb_width 640, blit opcode 1, end opcode 0.
module command_list_rect_fill
  import clrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // word
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // write_address, write_color
  output logic [3:0]  m_axis_tuser,   // write_valid, busy_res, status[1:0]
  output logic        m_axis_tlast,   // fill_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  res_t        res;
  res_t        res_q;
  logic        in_vld_q, out_vld_q;
  logic [31:0] word_q;
  mode_e       mode_q;
  logic        advance, fire;

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  clrf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clrf_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .mode_i (mode_q),
    .word_i (word_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      word_q <= s_axis_tdata;
      mode_q <= mode_e'(s_axis_tuser);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_q.write_color, res_q.write_address};
  assign m_axis_tuser  = {res_q.status, res_q.busy_res, res_q.write_valid};
  assign m_axis_tlast  = res_q.fill_last;

endmodule

// ===== hw/rtl/clrf_cfg_regs.sv =====
// Configuration registers of the rectangle fill block behind an APB-style port.
// Depends on clrf_pkg for the register indexes and the configuration struct.
module clrf_cfg_regs
  import clrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width    <= 16'd640;
      cfg_q.blit_opcode <= 16'd1;
      cfg_q.end_opcode  <= 16'd0;
    end else if (wr_en) begin
      case (idx)
        RegFbWidth:    cfg_q.fb_width    <= pwdata[HalfBits-1:0];
        RegBlitOpcode: cfg_q.blit_opcode <= pwdata[HalfBits-1:0];
        RegEndOpcode:  cfg_q.end_opcode  <= pwdata[HalfBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegFbWidth:    prdata = {16'd0, cfg_q.fb_width};
      RegBlitOpcode: prdata = {16'd0, cfg_q.blit_opcode};
      RegEndOpcode:  prdata = {16'd0, cfg_q.end_opcode};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/clrf_engine.sv =====
// Command decode, rectangle state and pixel address logic of the fill block.
// Depends on clrf_pkg; fed from the input register, drives the result register.
module clrf_engine
  import clrf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  mode_e       mode_i,
  input  logic [31:0] word_i,
  input  cfg_t        cfg_i,
  output res_t        res_o
);

  logic [1:0]  words_seen_q, words_seen_d;
  logic [15:0] rect_x_q, rect_x_d;
  logic [15:0] rect_y_q, rect_y_d;
  logic [15:0] rect_w_q, rect_w_d;
  logic [15:0] rect_h_q, rect_h_d;
  logic [31:0] color_q, color_d;
  logic [16:0] cur_x_q, cur_x_d;
  logic [16:0] cur_y_q, cur_y_d;
  logic        filling_q, filling_d;
  logic        halted_q, halted_d;

  logic [15:0] lo, hi;
  logic [16:0] row, col;
  logic [32:0] prod;
  logic [33:0] sum;
  logic [17:0] next_x, next_y;

  assign lo     = word_i[15:0];
  assign hi     = word_i[31:16];
  assign row    = {1'b0, rect_y_q} + cur_y_q;
  assign col    = {1'b0, rect_x_q} + cur_x_q;
  assign prod   = row * cfg_i.fb_width;
  assign sum    = {1'b0, prod} + {17'd0, col};
  assign next_x = {1'b0, cur_x_q} + 18'd1;
  assign next_y = {1'b0, cur_y_q} + 18'd1;

  always_comb begin
    words_seen_d = words_seen_q;
    rect_x_d     = rect_x_q;
    rect_y_d     = rect_y_q;
    rect_w_d     = rect_w_q;
    rect_h_d     = rect_h_q;
    color_d      = color_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    filling_d    = filling_q;
    halted_d     = halted_q;
    res_o.write_valid   = 1'b0;
    res_o.write_address = 32'd0;
    res_o.write_color   = 32'd0;
    res_o.fill_last     = 1'b0;
    res_o.status        = StOk;
    case (mode_i)
      ModeWord: begin
        if (halted_q) begin
          res_o.status = StHalted;
        end else if (filling_q) begin
          res_o.status = StBusy;
        end else begin
          case (words_seen_q)
            2'd0: begin
              if (lo == cfg_i.blit_opcode) begin
                rect_x_d     = hi;
                words_seen_d = 2'd1;
              end else if (lo == cfg_i.end_opcode) begin
                halted_d = 1'b1;
              end else begin
                halted_d     = 1'b1;
                res_o.status = StUnknownOp;
              end
            end
            2'd1: begin
              rect_y_d     = lo;
              rect_w_d     = hi;
              words_seen_d = 2'd2;
            end
            2'd2: begin
              rect_h_d     = lo;
              words_seen_d = 2'd3;
            end
            default: begin
              color_d      = word_i;
              words_seen_d = 2'd0;
              cur_x_d      = 17'd0;
              cur_y_d      = 17'd0;
              filling_d    = (rect_w_q != 16'd0) && (rect_h_q != 16'd0);
            end
          endcase
        end
      end
      ModeTick: begin
        if (filling_q) begin
          res_o.write_valid   = 1'b1;
          res_o.write_address = sum[31:0] & AddrMask;
          res_o.write_color   = color_q;
          if (next_x >= {2'd0, rect_w_q}) begin
            cur_x_d = 17'd0;
            if (next_y >= {2'd0, rect_h_q}) begin
              cur_y_d         = 17'd0;
              filling_d       = 1'b0;
              res_o.fill_last = 1'b1;
            end else begin
              cur_y_d = next_y[16:0];
            end
          end else begin
            cur_x_d = next_x[16:0];
          end
        end
      end
      ModeRestart: begin
        halted_d     = 1'b0;
        words_seen_d = 2'd0;
        filling_d    = 1'b0;
        cur_x_d      = 17'd0;
        cur_y_d      = 17'd0;
      end
      default: ;
    endcase
    res_o.busy_res = filling_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_seen_q <= 2'd0;
      rect_x_q     <= 16'd0;
      rect_y_q     <= 16'd0;
      rect_w_q     <= 16'd0;
      rect_h_q     <= 16'd0;
      color_q      <= 32'd0;
      cur_x_q      <= 17'd0;
      cur_y_q      <= 17'd0;
      filling_q    <= 1'b0;
      halted_q     <= 1'b0;
    end else if (fire_i) begin
      words_seen_q <= words_seen_d;
      rect_x_q     <= rect_x_d;
      rect_y_q     <= rect_y_d;
      rect_w_q     <= rect_w_d;
      rect_h_q     <= rect_h_d;
      color_q      <= color_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      filling_q    <= filling_d;
      halted_q     <= halted_d;
    end
  end

endmodule
